// ===== rtl/modbus_rtu_request_parser_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Modbus RTU request parser
// Two shorthands for clocked implication checks with a disable condition.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_PARSER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MRRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MRRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mrrp_pkg.sv =====
// ---------------------------------------------------------------------------
// mrrp_pkg
// Types, constants and helper functions shared by the request parser files.
// ---------------------------------------------------------------------------
package mrrp_pkg;

   localparam int MAX_BUFFER_WORDS = 256;
   localparam int BUF_W            = 9;    // holds 0..MAX_BUFFER_WORDS

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] IDLE_MAX = 16'hFFFF;
   localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'd16;

   localparam int RSP_DATA_W = 80;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_ID         = 2'd0,
      CSR_TIMEOUT_MS      = 2'd1,
      CSR_FUNCTION_ENABLE = 2'd2,
      CSR_BUFFER_WORDS    = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } req_kind_type;

   typedef enum logic {
      RESULT_WORD    = 1'b0,
      RESULT_VERDICT = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      VERDICT_EXECUTE          = 2'd0,
      VERDICT_ILLEGAL_FUNCTION = 2'd1,
      VERDICT_ILLEGAL_ADDRESS  = 2'd2
   } verdict_type;

   typedef enum logic [3:0] {
      PH_ID      = 4'd0,
      PH_FUNC    = 4'd1,
      PH_ADDR_HI = 4'd2,
      PH_ADDR_LO = 4'd3,
      PH_HEADER  = 4'd4,
      PH_VAL_HI  = 4'd5,
      PH_VAL_LO  = 4'd6,
      PH_CRC_LO  = 4'd7,
      PH_CRC_HI  = 4'd8
   } phase_type;

   // Work handed from front to back.
   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_ABANDON = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } q_entry_type;

   typedef struct packed {
      logic [Q_CNT_W-1:0] count;
      logic               full;
      logic               valid;
   } q_status_type;

   typedef struct packed {
      logic [7:0]       node_id;
      logic [15:0]      timeout_ms;
      logic [6:0]       function_enable;
      logic [BUF_W-1:0] buffer_words;
   } cfg_type;

   // Modbus CRC-16, one byte.
   function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                            input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic fn_enabled(input logic [7:0] fc, input logic [6:0] en);
      logic r;
      unique case (fc)
         8'd1:              r = en[0];
         8'd2:              r = en[1];
         8'd3:              r = en[2];
         8'd4:              r = en[3];
         8'd5:              r = en[4];
         8'd6:              r = en[5];
         FC_WRITE_MULTIPLE: r = en[6];
         default:           r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [BUF_W-1:0] buffer_limit(input logic [BUF_W-1:0] bw);
      return (bw > BUF_W'(MAX_BUFFER_WORDS)) ? BUF_W'(MAX_BUFFER_WORDS) : bw;
   endfunction

endpackage

// ===== rtl/mrrp_queue.sv =====
// ---------------------------------------------------------------------------
// mrrp_queue
// Short flop FIFO between the classifying front and the parsing back.
// ---------------------------------------------------------------------------
module mrrp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mrrp_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output mrrp_pkg::q_entry_type head_entry,
   output mrrp_pkg::q_status_type status
);

   mrrp_pkg::q_entry_type              mem_ff [mrrp_pkg::Q_DEPTH];
   logic [mrrp_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mrrp_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mrrp_pkg::Q_CNT_W-1:0]       count_ff, count_in;
   logic                               do_push, do_pop;

   assign do_push = push && (count_ff != mrrp_pkg::Q_CNT_W'(mrrp_pkg::Q_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == mrrp_pkg::Q_CNT_W'(mrrp_pkg::Q_DEPTH));
   assign status.valid = (count_ff != '0);

endmodule

// ===== rtl/mrrp_front.sv =====
// ---------------------------------------------------------------------------
// mrrp_front
// Accepts requests, tracks idle time and turns them into queue operations.
// ---------------------------------------------------------------------------
module mrrp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  logic [7:0]             req_tdata,
   input  logic [15:0]            timeout_ms,
   input  mrrp_pkg::q_status_type q_status,
   output logic                   push,
   output mrrp_pkg::q_entry_type  push_entry
);

   logic [15:0] idle_ff, idle_in;
   logic        accept;
   logic [15:0] idle_inc;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign idle_inc   = (idle_ff != mrrp_pkg::IDLE_MAX) ? idle_ff + 16'd1 : idle_ff;

   always_comb begin
      idle_in         = idle_ff;
      push            = 1'b0;
      push_entry.op   = mrrp_pkg::OP_BYTE;
      push_entry.data = req_tdata;
      if (accept) begin
         if (req_tuser == mrrp_pkg::KIND_TICK) begin
            idle_in = idle_inc;
            // only ticks that time out reach the parser
            if (idle_inc > timeout_ms) begin
               push          = 1'b1;
               push_entry.op = mrrp_pkg::OP_ABANDON;
            end
         end else begin
            idle_in = '0;
            push    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= '0;
      end else begin
         idle_ff <= idle_in;
      end
   end

endmodule

// ===== rtl/mrrp_back.sv =====
// ---------------------------------------------------------------------------
// mrrp_back
// Frame parser with running CRC and registered result output.
// ---------------------------------------------------------------------------
module mrrp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  mrrp_pkg::cfg_type                   cfg,
   input  logic                                q_valid,
   input  mrrp_pkg::q_entry_type               q_head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,
   output logic [mrrp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   mrrp_pkg::phase_type phase_ff, phase_in;
   logic        id_matched_ff, id_matched_in;
   logic        func_ok_ff, func_ok_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] expected_ff, expected_in;
   logic [15:0] wcount_ff, wcount_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  val_hi_ff, val_hi_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [15:0] rsp_index_ff, rsp_value_ff, rsp_addr_ff, rsp_count_ff;
   logic [7:0]  rsp_func_ff;
   logic [1:0]  rsp_verdict_ff;

   logic        res_valid;
   logic        res_kind;
   logic [15:0] res_index, res_value;
   logic [1:0]  res_verdict;

   logic [7:0]                  b;
   logic [15:0]                 crc_next;
   logic [15:0]                 wcount_next;
   logic [mrrp_pkg::BUF_W-1:0]  limit;

   assign pop         = q_valid && (!rsp_valid_ff || rsp_tready);
   assign b           = q_head.data;
   assign crc_next    = mrrp_pkg::crc_step(crc_ff, b);
   assign wcount_next = wcount_ff + 16'd1;
   assign limit       = mrrp_pkg::buffer_limit(cfg.buffer_words);

   always_comb begin
      phase_in      = phase_ff;
      id_matched_in = id_matched_ff;
      func_ok_in    = func_ok_ff;
      func_in       = func_ff;
      addr_in       = addr_ff;
      expected_in   = expected_ff;
      wcount_in     = wcount_ff;
      hdr_in        = hdr_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      val_hi_in     = val_hi_ff;
      crc_in        = crc_ff;
      crc_lo_in     = crc_lo_ff;
      res_valid     = 1'b0;
      res_kind      = mrrp_pkg::RESULT_WORD;
      res_index     = '0;
      res_value     = '0;
      res_verdict   = mrrp_pkg::VERDICT_EXECUTE;

      if (pop) begin
         if (q_head.op == mrrp_pkg::OP_ABANDON) begin
            phase_in = mrrp_pkg::PH_ID;
         end else begin
            if (id_matched_ff && phase_ff >= mrrp_pkg::PH_FUNC &&
                phase_ff <= mrrp_pkg::PH_VAL_LO) begin
               crc_in = crc_next;
            end
            unique case (phase_ff)
               mrrp_pkg::PH_FUNC: begin
                  func_in    = b;
                  func_ok_in = mrrp_pkg::fn_enabled(b, cfg.function_enable);
                  phase_in   = mrrp_pkg::PH_ADDR_HI;
               end
               mrrp_pkg::PH_ADDR_HI: begin
                  addr_in  = {b, 8'h00};
                  phase_in = mrrp_pkg::PH_ADDR_LO;
               end
               mrrp_pkg::PH_ADDR_LO: begin
                  addr_in = addr_ff + {8'h00, b};
                  if (func_ff == mrrp_pkg::FC_WRITE_MULTIPLE) begin
                     phase_in = mrrp_pkg::PH_HEADER;
                  end else begin
                     expected_in = 16'd1;
                     phase_in    = mrrp_pkg::PH_VAL_HI;
                  end
               end
               mrrp_pkg::PH_HEADER: begin
                  // quantity high, quantity low, byte count (ignored)
                  if (hdr_cnt_ff == 2'd0) begin
                     hdr_in = {b, 8'h00};
                  end else if (hdr_cnt_ff == 2'd1) begin
                     hdr_in = hdr_ff | {8'h00, b};
                  end
                  hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  if (hdr_cnt_ff == 2'd2) begin
                     hdr_cnt_in  = '0;
                     wcount_in   = '0;
                     expected_in = hdr_ff;
                     phase_in    = mrrp_pkg::PH_VAL_HI;
                  end
               end
               mrrp_pkg::PH_VAL_HI: begin
                  val_hi_in = b;
                  phase_in  = mrrp_pkg::PH_VAL_LO;
               end
               mrrp_pkg::PH_VAL_LO: begin
                  if (wcount_ff < {7'd0, limit}) begin
                     res_valid = 1'b1;
                     res_index = wcount_ff;
                     res_value = {val_hi_ff, b};
                  end
                  wcount_in = wcount_next;
                  phase_in  = (wcount_next == expected_ff) ? mrrp_pkg::PH_CRC_LO
                                                           : mrrp_pkg::PH_VAL_HI;
               end
               mrrp_pkg::PH_CRC_LO: begin
                  crc_lo_in = b;
                  phase_in  = mrrp_pkg::PH_CRC_HI;
               end
               mrrp_pkg::PH_CRC_HI: begin
                  phase_in = mrrp_pkg::PH_ID;
                  if (id_matched_ff && {b, crc_lo_ff} == crc_ff) begin
                     res_valid = 1'b1;
                     res_kind  = mrrp_pkg::RESULT_VERDICT;
                     if (expected_ff > {7'd0, limit}) begin
                        res_verdict = mrrp_pkg::VERDICT_ILLEGAL_ADDRESS;
                     end else if (!func_ok_ff) begin
                        res_verdict = mrrp_pkg::VERDICT_ILLEGAL_FUNCTION;
                     end
                  end
               end
               default: begin
                  // server id, also any stray phase code
                  id_matched_in = (b == cfg.node_id);
                  func_ok_in    = 1'b0;
                  addr_in       = '0;
                  wcount_in     = '0;
                  expected_in   = '0;
                  hdr_cnt_in    = '0;
                  crc_in        = (b == cfg.node_id) ?
                                  mrrp_pkg::crc_step(mrrp_pkg::CRC_INIT, b) :
                                  mrrp_pkg::CRC_INIT;
                  phase_in      = mrrp_pkg::PH_FUNC;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mrrp_pkg::PH_ID;
         id_matched_ff <= 1'b0;
         func_ok_ff    <= 1'b0;
         func_ff       <= '0;
         addr_ff       <= '0;
         expected_ff   <= '0;
         wcount_ff     <= '0;
         hdr_ff        <= '0;
         hdr_cnt_ff    <= '0;
         val_hi_ff     <= '0;
         crc_ff        <= mrrp_pkg::CRC_INIT;
         crc_lo_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         id_matched_ff <= id_matched_in;
         func_ok_ff    <= func_ok_in;
         func_ff       <= func_in;
         addr_ff       <= addr_in;
         expected_ff   <= expected_in;
         wcount_ff     <= wcount_in;
         hdr_ff        <= hdr_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         val_hi_ff     <= val_hi_in;
         crc_ff        <= crc_in;
         crc_lo_ff     <= crc_lo_in;
         if (pop) begin
            rsp_valid_ff <= res_valid;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         rsp_kind_ff    <= res_kind;
         rsp_index_ff   <= res_index;
         rsp_value_ff   <= res_value;
         rsp_func_ff    <= func_ff;
         rsp_addr_ff    <= addr_ff;
         rsp_count_ff   <= expected_ff;
         rsp_verdict_ff <= res_verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_verdict_ff, rsp_count_ff, rsp_addr_ff, rsp_func_ff,
                        rsp_value_ff, rsp_index_ff};

endmodule

// ===== rtl/modbus_rtu_request_parser.sv =====
// ---------------------------------------------------------------------------
// modbus_rtu_request_parser
// Modbus RTU server request parser: value words and frame verdicts.
// ---------------------------------------------------------------------------
// Each request is either a received byte (tuser 0) or a one millisecond idle
// tick (tuser 1). One request is taken every clock cycle when the result side
// keeps up; a result passes through the queue and the result register before
// it shows on rsp. The front stage tracks idle time and drops ticks that do
// not time out; the four-entry queue lets front and back stall independently.
// The back stage parses the frame and folds each byte into the Modbus CRC-16
// combinationally, which sets the one-request-per-cycle rate. A value word is
// reported for each word whose index is below the buffer size (capped at 256),
// whatever the id or CRC; a verdict follows a frame whose id matched and
// whose CRC is good. Wrong-id and bad-CRC frames give no verdict. There is no
// clearing pass after reset. The user must write registers through csr_* only
// while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`include "modbus_rtu_request_parser_assert.svh"

module modbus_rtu_request_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic                                   req_tuser,   // kind
   input  logic [7:0]                             req_tdata,   // byte_value
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tuser,   // result_kind
   // word_index[15:0], word_value[31:16], function_code[39:32],
   // start_address[55:40], word_count[71:56], verdict[73:72], zero pad
   output logic [mrrp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // register write port
   input  logic                                   csr_we,
   input  logic [mrrp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mrrp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   mrrp_pkg::cfg_type      cfg_ff;
   mrrp_pkg::q_status_type q_stat;
   mrrp_pkg::q_entry_type  push_entry, head_entry;
   logic                   push, pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id         <= 8'd1;
         cfg_ff.timeout_ms      <= 16'd2;
         cfg_ff.function_enable <= 7'h7F;
         cfg_ff.buffer_words    <= mrrp_pkg::BUF_W'(64);
      end else if (csr_we) begin
         unique case (mrrp_pkg::csr_index_type'(csr_index))
            mrrp_pkg::CSR_NODE_ID:         cfg_ff.node_id         <= csr_wdata[7:0];
            mrrp_pkg::CSR_TIMEOUT_MS:      cfg_ff.timeout_ms      <= csr_wdata;
            mrrp_pkg::CSR_FUNCTION_ENABLE: cfg_ff.function_enable <= csr_wdata[6:0];
            mrrp_pkg::CSR_BUFFER_WORDS:
               cfg_ff.buffer_words <= csr_wdata[mrrp_pkg::BUF_W-1:0];
            default: ;
         endcase
      end
   end

   // front: accept and classify
   mrrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .timeout_ms (cfg_ff.timeout_ms),
      .q_status   (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   mrrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_stat)
   );

   // back: parse, CRC, results
   mrrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_stat.valid),
      .q_head     (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // checks
   `MRRP_ASSERT_IMP(a_ready_tracks_queue, clock, reset, !req_tready, q_stat.count == mrrp_pkg::Q_CNT_W'(mrrp_pkg::Q_DEPTH), "request stalled while queue has room")
   `MRRP_ASSERT_IMP(a_word_has_no_verdict, clock, reset, rsp_tvalid && rsp_tuser == mrrp_pkg::RESULT_WORD, rsp_tdata[73:72] == mrrp_pkg::VERDICT_EXECUTE, "value word carries a verdict")
   `MRRP_ASSERT_IMP(a_verdict_clean, clock, reset, rsp_tvalid && rsp_tuser == mrrp_pkg::RESULT_VERDICT, rsp_tdata[31:0] == 32'd0 && rsp_tdata[73:72] != 2'd3, "malformed verdict")
   `MRRP_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid && q_stat.count == '0, "reset left work pending")

endmodule
